@@ rtl/core/sparse_column_run_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Sparse column run encoder assertion macros
// Concurrent check wrappers; empty when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_RUN_ENCODER_ASSERT_SVH
`define SPARSE_COLUMN_RUN_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scre assertion failed");
`define SCRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scre assertion failed");
`else
`define SCRE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SCRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/scre_pkg.sv @@
// ----------------------------------------------------------------------------
// scre_pkg
// Shared types and constants of the sparse column run encoder.
// ----------------------------------------------------------------------------
package scre_pkg;

    localparam longint unsigned MAX_ROWS_DEFAULT = 64'd65536;
    localparam longint unsigned ROW_LIMIT        = 64'd65536;
    localparam logic [16:0]     NUM_ROWS_RESET   = 17'h10000;
    localparam int unsigned     QUEUE_DEPTH      = 2;

    localparam logic CMD_ENTRY = 1'b0;
    localparam logic CMD_EMPTY = 1'b1;

    // Up to three runs per item: zero run before, value run, trailing zero run
    typedef struct packed {
        logic        a_en;
        logic [15:0] a_start;
        logic [16:0] a_len;
        logic        a_first;
        logic        a_last;
        logic        b_en;
        logic [63:0] b_value;
        logic [15:0] b_row;
        logic        b_first;
        logic        b_last;
        logic        c_en;
        logic [15:0] c_start;
        logic [16:0] c_len;
    } job_t;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] row_start;
        logic [16:0] length;
        logic [31:0] index;
        logic        first_col;
        logic        last_col;
        logic        last_res;
    } run_t;

endpackage

@@ rtl/core/sparse_column_run_encoder.sv @@
// ----------------------------------------------------------------------------
// sparse_column_run_encoder
// Turns a stream of compressed-sparse-column entries into run-length form.
// ----------------------------------------------------------------------------
// Each accepted word yields one to three runs (gap/leading zeros, value run,
// trailing zeros), or a single full-column zero run for an empty column. The
// front end takes a word every cycle while its two-entry job queue has room;
// the emitter drives one run per cycle while m_tready does not stall it, from its
// single output register. num_rows is written over the cfg channel by the user
// only while the block is idle, which the block does not enforce; reset value 65536.
// ----------------------------------------------------------------------------
`include "sparse_column_run_encoder_assert.svh"

module sparse_column_run_encoder #(
    parameter longint unsigned MAX_ROWS = scre_pkg::MAX_ROWS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [16:0]   cfg_data,     // num_rows
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [79:0]   s_tdata,      // row_index[15:0], entry_value[79:16]
    input  logic          s_tuser,      // cmd
    input  logic          s_tlast,      // last_in_column
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,      // run_value[63:0], run_row_start[79:64],
                                        // run_length[96:80], run_index[128:97]
    output logic [1:0]    m_tuser,      // first_of_column[0], last_result[1]
    output logic          m_tlast       // last_of_column
);

    scre_pkg::job_t front_job, head_job;
    scre_pkg::run_t out_run;
    logic           q_full, head_valid, pop;

    assign s_tready = !q_full;

    scre_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_row    (s_tdata[15:0]),
        .in_value  (s_tdata[79:16]),
        .in_last   (s_tlast),
        .accept    (s_tready),
        .job       (front_job)
    );

    scre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid && s_tready),
        .push_job   (front_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    scre_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_run    (out_run)
    );

    assign m_tdata = {7'd0, out_run.index, out_run.length, out_run.row_start, out_run.value};
    assign m_tuser = {out_run.last_res, out_run.first_col};
    assign m_tlast = out_run.last_col;

    `SCRE_ASSERT_IMPL(a_len_nonzero, aclk, aresetn, m_tvalid, m_tdata[96:80] != 17'd0)

    `SCRE_ASSERT_IMPL(a_run_in_column, aclk, aresetn, m_tvalid,
        ({2'b00, m_tdata[79:64]} + {1'b0, m_tdata[96:80]}) <= 18'h10000)

    `SCRE_ASSERT_IMPL(a_index_steps, aclk, aresetn,
        m_tvalid && $past(m_tvalid && m_tready) && ($past(m_tdata[128:97]) != 32'hFFFF_FFFF),
        m_tdata[128:97] == 32'($past(m_tdata[128:97]) + 32'd1))

endmodule

@@ rtl/core/scre_front.sv @@
// ----------------------------------------------------------------------------
// scre_front
// Accepts entries, tracks column state and classifies each item into runs.
// ----------------------------------------------------------------------------
module scre_front #(
    parameter longint unsigned MAX_ROWS = scre_pkg::MAX_ROWS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_cmd,
    input  logic [15:0]        in_row,
    input  logic [63:0]        in_value,
    input  logic               in_last,
    input  logic               accept,
    output scre_pkg::job_t     job
);

    localparam longint unsigned CapFull =
        (MAX_ROWS < scre_pkg::ROW_LIMIT) ? MAX_ROWS : scre_pkg::ROW_LIMIT;
    localparam logic [16:0] RowCap = 17'(CapFull);

    logic [16:0] num_rows_reg, num_rows_next;
    logic [15:0] prev_reg, prev_next;
    logic        has_prev_reg, has_prev_next;

    logic [16:0] rows_eff;
    logic [15:0] row_max, row_c;
    logic [16:0] row17, row_p1, prev_p1;
    logic        trail;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (num_rows_reg == 17'd0) begin
            rows_eff = 17'd1;
        end else if (num_rows_reg > RowCap) begin
            rows_eff = RowCap;
        end else begin
            rows_eff = num_rows_reg;
        end
        row_max = 16'(rows_eff - 17'd1);
        row_c   = (in_row > row_max) ? row_max : in_row;
        row17   = {1'b0, row_c};
        row_p1  = row17 + 17'd1;
        prev_p1 = {1'b0, prev_reg} + 17'd1;
        trail   = in_last && (row_p1 < rows_eff);

        job.a_en    = has_prev_reg ? (row17 > prev_p1) : (row_c != 16'd0);
        job.a_start = has_prev_reg ? prev_p1[15:0] : 16'd0;
        job.a_len   = has_prev_reg ? 17'(row17 - prev_p1) : row17;
        job.a_first = !has_prev_reg;
        job.a_last  = 1'b0;
        job.b_en    = 1'b1;
        job.b_value = in_value;
        job.b_row   = row_c;
        job.b_first = !has_prev_reg && (row_c == 16'd0);
        job.b_last  = in_last && !trail;
        job.c_en    = trail;
        job.c_start = row_p1[15:0];
        job.c_len   = 17'(rows_eff - row_p1);

        // empty column: one zero run over every row
        if (in_cmd == scre_pkg::CMD_EMPTY) begin
            job.a_en    = 1'b1;
            job.a_start = 16'd0;
            job.a_len   = rows_eff;
            job.a_first = 1'b1;
            job.a_last  = 1'b1;
            job.b_en    = 1'b0;
            job.c_en    = 1'b0;
        end

        num_rows_next = cfg_valid ? cfg_data : num_rows_reg;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        if (in_valid && accept) begin
            if (in_cmd == scre_pkg::CMD_EMPTY) begin
                has_prev_next = 1'b0;
            end else begin
                prev_next     = row_c;
                has_prev_next = !in_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= scre_pkg::NUM_ROWS_RESET;
            prev_reg     <= 16'd0;
            has_prev_reg <= 1'b0;
        end else begin
            num_rows_reg <= num_rows_next;
            prev_reg     <= prev_next;
            has_prev_reg <= has_prev_next;
        end
    end

endmodule

@@ rtl/core/scre_queue.sv @@
// ----------------------------------------------------------------------------
// scre_queue
// Short job queue between the classifier and the run emitter.
// ----------------------------------------------------------------------------
module scre_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scre_pkg::job_t push_job,
    output logic           full,
    output logic           head_valid,
    output scre_pkg::job_t head_job,
    input  logic           pop
);

    localparam int unsigned Depth = scre_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW  = $clog2(Depth + 1);

    scre_pkg::job_t slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
    endfunction

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CntW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CntW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/scre_back.sv @@
// ----------------------------------------------------------------------------
// scre_back
// Emits the runs of the head job, one per cycle unless out_ready stalls it, into the output register.
// ----------------------------------------------------------------------------
module scre_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  scre_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output scre_pkg::run_t out_run
);

    logic [2:0]     done_reg, done_next, en, rem, sel;
    logic [31:0]    counter_reg, counter_next;
    logic           valid_reg, valid_next;
    scre_pkg::run_t run_reg, run_next;
    logic           load, last_res;

    always_comb begin
        en  = {head_job.c_en, head_job.b_en, head_job.a_en};
        rem = en & ~done_reg;
        if (rem[0]) begin
            sel = 3'b001;
        end else if (rem[1]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
        last_res = ((rem & ~sel) == 3'b000);
        load     = head_valid && (!valid_reg || out_ready);
        pop      = load && last_res;

        run_next          = run_reg;
        run_next.index    = counter_reg;
        run_next.last_res = last_res;
        unique case (sel)
            3'b001: begin
                run_next.value     = 64'd0;
                run_next.row_start = head_job.a_start;
                run_next.length    = head_job.a_len;
                run_next.first_col = head_job.a_first;
                run_next.last_col  = head_job.a_last;
            end
            3'b010: begin
                run_next.value     = head_job.b_value;
                run_next.row_start = head_job.b_row;
                run_next.length    = 17'd1;
                run_next.first_col = head_job.b_first;
                run_next.last_col  = head_job.b_last;
            end
            default: begin
                run_next.value     = 64'd0;
                run_next.row_start = head_job.c_start;
                run_next.length    = head_job.c_len;
                run_next.first_col = 1'b0;
                run_next.last_col  = 1'b1;
            end
        endcase

        valid_next   = valid_reg;
        done_next    = done_reg;
        counter_next = counter_reg;
        if (load) begin
            valid_next = 1'b1;
            done_next  = last_res ? 3'b000 : (done_reg | sel);
            if (counter_reg != 32'hFFFF_FFFF) begin
                counter_next = counter_reg + 32'd1;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            done_reg    <= 3'b000;
            counter_reg <= 32'd0;
        end else begin
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            counter_reg <= counter_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_run   = run_reg;

endmodule
